/* hdl/look_at_view_matrix_core_assert.svh */
// assertion macros for the look-at view matrix core checker
// depends on nothing; taken in by the checker file
`ifndef LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define LAVM_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("lavm assertion failed");

// condition must hold in the cycle after the trigger
`define LAVM_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("lavm assertion failed");

`endif

/* hdl/lavm_pkg.sv */
// shared constants, types and arithmetic helpers of the look-at view matrix core
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lavm_pkg;

   // pipeline geometry
   localparam int SQ_STAGES  = 32;
   localparam int DIV_STAGES = 16;
   localparam int PIPE_DEPTH = 2 * SQ_STAGES + 2 * DIV_STAGES + 14;

   localparam logic [15:0] ONE_Q14 = 16'd16384;
   localparam int MG_W = 21;

   // axis slots in the translation stage
   localparam int AX_LX = 0;
   localparam int AX_LZ = 1;
   localparam int AX_UX = 2;
   localparam int AX_UY = 3;
   localparam int AX_UZ = 4;
   localparam int AX_FX = 5;
   localparam int AX_FY = 6;
   localparam int AX_FZ = 7;

   // one digit of the square root recurrence
   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sq_type;

   // one quotient bit of the restoring divider
   typedef struct packed {
      logic [33:0] rem;
      logic [15:0] nlo;
      logic [15:0] quo;
   } div_type;

   function automatic sq_type sqrt_step(input sq_type s);
      logic [35:0] acc;
      logic [35:0] trial;
      sq_type r;
      acc   = {s.rem, s.rad[63:62]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[61:0], 2'b00};
      if (acc >= trial) begin
         r.rem  = 34'(acc - trial);
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem  = acc[33:0];
         r.root = {s.root[30:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_type div_init(input logic [47:0] num);
      div_type r;
      r.rem = {2'b00, num[47:16]};
      r.nlo = num[15:0];
      r.quo = '0;
      return r;
   endfunction

   function automatic div_type div_step(input div_type d, input logic [33:0] den);
      logic [34:0] acc;
      div_type r;
      acc   = {d.rem, d.nlo[15]};
      r.nlo = {d.nlo[14:0], 1'b0};
      if (acc >= {1'b0, den}) begin
         r.rem = 34'(acc - {1'b0, den});
         r.quo = {d.quo[14:0], 1'b1};
      end else begin
         r.rem = acc[33:0];
         r.quo = {d.quo[14:0], 1'b0};
      end
      return r;
   endfunction

   // clamp an unsigned quotient to one and apply a sign
   function automatic logic [15:0] fix_sign(input logic [15:0] q, input logic neg);
      logic [15:0] m;
      m = (q > ONE_Q14) ? ONE_Q14 : q;
      return neg ? 16'(-m) : m;
   endfunction

   // shift right by 14, round half away from zero
   function automatic logic signed [63:0] rsh14(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + 64'd8192) >> 14;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [15:0] clamp_q14(input logic signed [63:0] v);
      logic [15:0] r;
      if (v > 64'sd16384) begin
         r = ONE_Q14;
      end else if (v < -64'sd16384) begin
         r = 16'(-ONE_Q14);
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/lavm_if.sv */
// valid/ready channel interfaces for the look-at view matrix core
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface lavm_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] look_x;
   logic signed [31:0] look_y;
   logic signed [31:0] look_z;
   modport source (output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
                 output ready);
endinterface

interface lavm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_x;
   logic signed [15:0] left_z;
   logic signed [15:0] up_x;
   logic signed [15:0] up_y;
   logic signed [15:0] up_z;
   logic signed [15:0] fwd_x;
   logic signed [15:0] fwd_y;
   logic signed [15:0] fwd_z;
   logic signed [31:0] trans_left;
   logic signed [31:0] trans_up;
   logic signed [31:0] trans_fwd;
   logic               degenerate;
   modport source (output valid, left_x, left_z, up_x, up_y, up_z, fwd_x, fwd_y,
                   fwd_z, trans_left, trans_up, trans_fwd, degenerate,
                   input ready);
   modport sink (input valid, left_x, left_z, up_x, up_y, up_z, fwd_x, fwd_y,
                 fwd_z, trans_left, trans_up, trans_fwd, degenerate,
                 output ready);
endinterface

`default_nettype wire

/* hdl/look_at_view_matrix_core.sv */
// look-at view matrix core: position and direction in, view matrix entries out
// depends on lavm_pkg and the channel interfaces in lavm_if.sv
//
// usage
//   req_ch carries one camera position and one view direction (Q15.16); a
//   transfer happens on a clock edge with valid and ready both high.
//   rsp_ch carries the left, up and forward axes (Q1.14), the three
//   translations (Q15.16, saturated) and a degenerate flag.
//   depth: 110 register stages, set by two 32-stage square root pipelines,
//   two 16-stage divider banks and the product, rounding and translation
//   stages around them.
//   throughput: one item per cycle unless stalled; every stage holds one item.
//   stall: when a response waits and rsp_ch.ready is low the whole pipeline
//   holds and req_ch.ready drops; nothing is lost or repeated.
//   reset: synchronous, clears all valid bits; data registers are not reset.
//   degenerate: a zero or vertical direction gives all zero fields with the
//   flag set.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_core
   import lavm_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   lavm_req_if.sink    req_ch,
   lavm_rsp_if.source  rsp_ch
);

   typedef struct packed {
      logic [2:0][MG_W-1:0] mg;
      logic [2:0]           neg;
      logic [2:0][31:0]     pos;
      logic                 zero;
   } pl1_type;

   typedef struct packed {
      logic [2:0]       neg;
      logic [2:0][31:0] pos;
      logic             zero;
      logic [33:0]      den;
   } pl2_type;

   typedef struct packed {
      logic [2:0][15:0] f;
      logic [2:0][31:0] pos;
      logic             deg;
      logic [33:0]      den;
   } pl4_type;

   typedef struct packed {
      logic [2:0][15:0] f;
      logic [15:0]      lx;
      logic [15:0]      lz;
      logic [2:0][31:0] pos;
      logic             deg;
   } pl6_type;

   typedef struct packed {
      logic [7:0][15:0] ax;
      logic [2:0][31:0] pos;
      logic             deg;
   } pl7_type;

   // valid bits and stall control
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  adv;

   assign adv          = !vld_ff[PIPE_DEPTH-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_ch.valid};
      end
   end

   // stage a: magnitudes and signs
   logic [2:0][31:0] look_in;
   logic [2:0][31:0] a_mag_ff, a_mag_in;
   logic [2:0]       a_neg_ff;
   logic [2:0][31:0] a_pos_ff;

   assign look_in = {req_ch.look_z, req_ch.look_y, req_ch.look_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = look_in[i][31] ? 32'(-look_in[i]) : look_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff <= a_mag_in;
         a_neg_ff <= {look_in[2][31], look_in[1][31], look_in[0][31]};
         a_pos_ff <= {req_ch.pos_z, req_ch.pos_y, req_ch.pos_x};
      end
   end

   // stage b: largest magnitude and its leading one
   logic [31:0]      b_max;
   logic [4:0]       b_msb_ff, b_msb_in;
   logic             b_zero_ff;
   logic [2:0][31:0] b_mag_ff;
   logic [2:0]       b_neg_ff;
   logic [2:0][31:0] b_pos_ff;

   always_comb begin
      b_max = a_mag_ff[0];
      if (a_mag_ff[1] > b_max) begin
         b_max = a_mag_ff[1];
      end
      if (a_mag_ff[2] > b_max) begin
         b_max = a_mag_ff[2];
      end
      b_msb_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (b_max[i]) begin
            b_msb_in = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_msb_ff  <= b_msb_in;
         b_zero_ff <= (b_max == '0);
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         b_pos_ff  <= a_pos_ff;
      end
   end

   // stage c: common shift puts the largest magnitude in [2^20, 2^21)
   pl1_type c_pl_ff, c_pl_in;

   always_comb begin
      logic [31:0] sh;
      c_pl_in.neg  = b_neg_ff;
      c_pl_in.pos  = b_pos_ff;
      c_pl_in.zero = b_zero_ff;
      for (int i = 0; i < 3; i++) begin
         if (b_msb_ff > 5'd20) begin
            sh = b_mag_ff[i] >> (b_msb_ff - 5'd20);
         end else begin
            sh = b_mag_ff[i] << (5'd20 - b_msb_ff);
         end
         c_pl_in.mg[i] = sh[MG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_pl_ff <= c_pl_in;
      end
   end

   // stage d: squares
   logic [2:0][41:0] d_sq_ff;
   pl1_type          d_pl_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            d_sq_ff[i] <= c_pl_ff.mg[i] * c_pl_ff.mg[i];
         end
         d_pl_ff <= c_pl_ff;
      end
   end

   // stage e: sum of squares
   logic [43:0] e_s_ff;
   pl1_type     e_pl_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e_s_ff  <= 44'(d_sq_ff[0]) + 44'(d_sq_ff[1]) + 44'(d_sq_ff[2]);
         e_pl_ff <= d_pl_ff;
      end
   end

   // first square root: one result bit per stage
   sq_type  sq1_in;
   sq_type  sq1_ff [SQ_STAGES];
   pl1_type s1_ff  [SQ_STAGES];

   assign sq1_in = '{rem: '0, root: '0, rad: {e_s_ff, 20'b0}};

   always_ff @(posedge clock) begin
      if (adv) begin
         sq1_ff[0] <= sqrt_step(sq1_in);
         s1_ff[0]  <= e_pl_ff;
         for (int k = 1; k < SQ_STAGES; k++) begin
            sq1_ff[k] <= sqrt_step(sq1_ff[k-1]);
            s1_ff[k]  <= s1_ff[k-1];
         end
      end
   end

   // first divider bank: forward components
   logic [31:0]          len1;
   logic [2:0][47:0]     num1;
   pl2_type              dv1_pl_in;
   div_type              dv1_ff [3][DIV_STAGES];
   pl2_type              p2_ff  [DIV_STAGES];

   assign len1 = sq1_ff[SQ_STAGES-1].root;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num1[i] = 48'({s1_ff[SQ_STAGES-1].mg[i], 25'b0}) + 48'(len1);
      end
      dv1_pl_in.neg  = s1_ff[SQ_STAGES-1].neg;
      dv1_pl_in.pos  = s1_ff[SQ_STAGES-1].pos;
      dv1_pl_in.zero = s1_ff[SQ_STAGES-1].zero;
      dv1_pl_in.den  = {1'b0, len1, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv1_ff[i][0] <= div_step(div_init(num1[i]), dv1_pl_in.den);
            for (int k = 1; k < DIV_STAGES; k++) begin
               dv1_ff[i][k] <= div_step(dv1_ff[i][k-1], p2_ff[k-1].den);
            end
         end
         p2_ff[0] <= dv1_pl_in;
         for (int k = 1; k < DIV_STAGES; k++) begin
            p2_ff[k] <= p2_ff[k-1];
         end
      end
   end

   // stage f: forward, clamped and signed
   logic [2:0][15:0] f_f_ff;
   logic [2:0][31:0] f_pos_ff;
   logic             f_zero_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            f_f_ff[i] <= fix_sign(dv1_ff[i][DIV_STAGES-1].quo,
                                  p2_ff[DIV_STAGES-1].neg[i]);
         end
         f_pos_ff  <= p2_ff[DIV_STAGES-1].pos;
         f_zero_ff <= p2_ff[DIV_STAGES-1].zero;
      end
   end

   // stage g: horizontal squares and degenerate test
   logic signed [31:0] g_p0, g_p2;
   logic [28:0]        g_sq0_ff, g_sq2_ff;
   pl4_type            g_pl_ff;

   always_comb begin
      g_p0 = $signed(f_f_ff[0]) * $signed(f_f_ff[0]);
      g_p2 = $signed(f_f_ff[2]) * $signed(f_f_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_sq0_ff    <= g_p0[28:0];
         g_sq2_ff    <= g_p2[28:0];
         g_pl_ff.f   <= f_f_ff;
         g_pl_ff.pos <= f_pos_ff;
         g_pl_ff.deg <= f_zero_ff || (f_f_ff[0] == '0 && f_f_ff[2] == '0);
         g_pl_ff.den <= '0;
      end
   end

   // stage h: horizontal length squared
   logic [29:0] h_h_ff;
   pl4_type     h_pl_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         h_h_ff  <= 30'(g_sq0_ff) + 30'(g_sq2_ff);
         h_pl_ff <= g_pl_ff;
      end
   end

   // second square root; the radicand carries six extra bits, dropped as three
   sq_type  sq2_in;
   sq_type  sq2_ff [SQ_STAGES];
   pl4_type s2_ff  [SQ_STAGES];

   assign sq2_in = '{rem: '0, root: '0, rad: {h_h_ff, 34'b0}};

   always_ff @(posedge clock) begin
      if (adv) begin
         sq2_ff[0] <= sqrt_step(sq2_in);
         s2_ff[0]  <= h_pl_ff;
         for (int k = 1; k < SQ_STAGES; k++) begin
            sq2_ff[k] <= sqrt_step(sq2_ff[k-1]);
            s2_ff[k]  <= s2_ff[k-1];
         end
      end
   end

   // second divider bank: left components
   logic [28:0]      len2;
   logic [15:0]      abs_f0, abs_f2;
   logic [47:0]      num_lx, num_lz;
   pl4_type          dv2_pl_in;
   div_type          dv2_ff [2][DIV_STAGES];
   pl4_type          p4_ff  [DIV_STAGES];

   always_comb begin
      len2      = sq2_ff[SQ_STAGES-1].root[31:3];
      dv2_pl_in = s2_ff[SQ_STAGES-1];
      abs_f0    = dv2_pl_in.f[0][15] ? 16'(-dv2_pl_in.f[0]) : dv2_pl_in.f[0];
      abs_f2    = dv2_pl_in.f[2][15] ? 16'(-dv2_pl_in.f[2]) : dv2_pl_in.f[2];
      num_lx    = 48'({abs_f2[14:0], 29'b0}) + 48'(len2);
      num_lz    = 48'({abs_f0[14:0], 29'b0}) + 48'(len2);
      dv2_pl_in.den = {4'b0, len2, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv2_ff[0][0] <= div_step(div_init(num_lx), dv2_pl_in.den);
         dv2_ff[1][0] <= div_step(div_init(num_lz), dv2_pl_in.den);
         for (int i = 0; i < 2; i++) begin
            for (int k = 1; k < DIV_STAGES; k++) begin
               dv2_ff[i][k] <= div_step(dv2_ff[i][k-1], p4_ff[k-1].den);
            end
         end
         p4_ff[0] <= dv2_pl_in;
         for (int k = 1; k < DIV_STAGES; k++) begin
            p4_ff[k] <= p4_ff[k-1];
         end
      end
   end

   // stage l: left axis, clamped and signed
   pl4_type l_src;
   pl6_type l_pl_ff;
   logic    f0_pos;

   assign l_src  = p4_ff[DIV_STAGES-1];
   assign f0_pos = !l_src.f[0][15] && (l_src.f[0] != '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         l_pl_ff.f   <= l_src.f;
         l_pl_ff.lx  <= fix_sign(dv2_ff[0][DIV_STAGES-1].quo, l_src.f[2][15]);
         l_pl_ff.lz  <= fix_sign(dv2_ff[1][DIV_STAGES-1].quo, f0_pos);
         l_pl_ff.pos <= l_src.pos;
         l_pl_ff.deg <= l_src.deg;
      end
   end

   // stage m: cross product terms for up
   logic signed [3:0][31:0] m_p_in;
   logic [3:0][31:0]        m_p_ff;
   pl6_type                 m_pl_ff;

   always_comb begin
      m_p_in[0] = $signed(l_pl_ff.f[1]) * $signed(l_pl_ff.lz);
      m_p_in[1] = $signed(l_pl_ff.f[2]) * $signed(l_pl_ff.lx);
      m_p_in[2] = $signed(l_pl_ff.f[0]) * $signed(l_pl_ff.lz);
      m_p_in[3] = $signed(l_pl_ff.f[1]) * $signed(l_pl_ff.lx);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_p_ff  <= m_p_in;
         m_pl_ff <= l_pl_ff;
      end
   end

   // stage n: up axis rounded to q1.14
   logic signed [63:0] n_t0, n_t1, n_t2, n_t3;
   pl7_type            n_pl_ff, n_pl_in;

   always_comb begin
      n_t0 = $signed(m_p_ff[0]);
      n_t1 = $signed(m_p_ff[1]);
      n_t2 = $signed(m_p_ff[2]);
      n_t3 = $signed(m_p_ff[3]);
      n_pl_in.ax[AX_LX] = m_pl_ff.lx;
      n_pl_in.ax[AX_LZ] = m_pl_ff.lz;
      n_pl_in.ax[AX_UX] = clamp_q14(rsh14(n_t0));
      n_pl_in.ax[AX_UY] = clamp_q14(rsh14(n_t1 - n_t2));
      n_pl_in.ax[AX_UZ] = clamp_q14(rsh14(-n_t3));
      n_pl_in.ax[AX_FX] = m_pl_ff.f[0];
      n_pl_in.ax[AX_FY] = m_pl_ff.f[1];
      n_pl_in.ax[AX_FZ] = m_pl_ff.f[2];
      n_pl_in.pos       = m_pl_ff.pos;
      n_pl_in.deg       = m_pl_ff.deg;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_pl_ff <= n_pl_in;
      end
   end

   // stage p: axis by position products
   logic signed [7:0][47:0] p_pr_in;
   logic [7:0][47:0]        p_pr_ff;
   pl7_type                 p_pl_ff;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         // position component paired with each axis slot
         case (k)
            AX_LX, AX_UX, AX_FX: p_pr_in[k] = $signed(n_pl_ff.ax[k]) *
                                              $signed(n_pl_ff.pos[0]);
            AX_UY, AX_FY:        p_pr_in[k] = $signed(n_pl_ff.ax[k]) *
                                              $signed(n_pl_ff.pos[1]);
            default:             p_pr_in[k] = $signed(n_pl_ff.ax[k]) *
                                              $signed(n_pl_ff.pos[2]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_pr_ff <= p_pr_in;
         p_pl_ff <= n_pl_ff;
      end
   end

   // stage q: negated dot products
   logic signed [7:0][63:0] q_x;
   logic signed [63:0]      q_tl, q_tu, q_tf;
   logic [2:0][49:0]        q_t_ff;
   pl7_type                 q_pl_ff;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         q_x[k] = $signed(p_pr_ff[k]);
      end
      q_tl = -(q_x[AX_LX] + q_x[AX_LZ]);
      q_tu = -(q_x[AX_UX] + q_x[AX_UY] + q_x[AX_UZ]);
      q_tf = -(q_x[AX_FX] + q_x[AX_FY] + q_x[AX_FZ]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_t_ff  <= {q_tf[49:0], q_tu[49:0], q_tl[49:0]};
         q_pl_ff <= p_pl_ff;
      end
   end

   // stage r: rounding, saturation and the output register
   logic [7:0][15:0] r_ax_ff;
   logic [2:0][31:0] r_t_ff;
   logic             r_deg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         r_deg_ff <= q_pl_ff.deg;
         if (q_pl_ff.deg) begin
            r_ax_ff <= '0;
            r_t_ff  <= '0;
         end else begin
            r_ax_ff <= q_pl_ff.ax;
            for (int i = 0; i < 3; i++) begin
               r_t_ff[i] <= sat32(rsh14(64'($signed(q_t_ff[i]))));
            end
         end
      end
   end

   assign rsp_ch.valid      = vld_ff[PIPE_DEPTH-1];
   assign rsp_ch.left_x     = r_ax_ff[AX_LX];
   assign rsp_ch.left_z     = r_ax_ff[AX_LZ];
   assign rsp_ch.up_x       = r_ax_ff[AX_UX];
   assign rsp_ch.up_y       = r_ax_ff[AX_UY];
   assign rsp_ch.up_z       = r_ax_ff[AX_UZ];
   assign rsp_ch.fwd_x      = r_ax_ff[AX_FX];
   assign rsp_ch.fwd_y      = r_ax_ff[AX_FY];
   assign rsp_ch.fwd_z      = r_ax_ff[AX_FZ];
   assign rsp_ch.trans_left = r_t_ff[0];
   assign rsp_ch.trans_up   = r_t_ff[1];
   assign rsp_ch.trans_fwd  = r_t_ff[2];
   assign rsp_ch.degenerate = r_deg_ff;

endmodule

`default_nettype wire

/* hdl/lavm_checker.sv */
// port-level checker for the look-at view matrix core, bound to the top level
// depends on look_at_view_matrix_core_assert.svh and look_at_view_matrix_core
`timescale 1ns / 1ps
`default_nettype none
`include "look_at_view_matrix_core_assert.svh"

module lavm_sva_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] left_x,
   input wire logic [15:0] left_z,
   input wire logic [15:0] fwd_x,
   input wire logic [15:0] fwd_z,
   input wire logic [31:0] trans_fwd,
   input wire logic        degenerate
);

   logic fields_zero;

   // all watched fields are zero
   assign fields_zero = left_x == 16'd0 && left_z == 16'd0 && fwd_x == 16'd0 &&
                        fwd_z == 16'd0 && trans_fwd == 32'd0;

   // a waiting response stays until its transfer
   `LAVM_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // an empty output stage always lets a request in
   `LAVM_ASSERT_SAME(ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // degenerate responses carry zero fields
   `LAVM_ASSERT_SAME(degenerate_zero, clock, reset, rsp_valid && degenerate, fields_zero)

   // a normal response has a nonzero left axis
   `LAVM_ASSERT_SAME(left_nonzero, clock, reset, rsp_valid && !degenerate, left_x != 16'd0 || left_z != 16'd0)

endmodule

bind look_at_view_matrix_core lavm_sva_checker u_lavm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .left_x     (rsp_ch.left_x),
   .left_z     (rsp_ch.left_z),
   .fwd_x      (rsp_ch.fwd_x),
   .fwd_z      (rsp_ch.fwd_z),
   .trans_fwd  (rsp_ch.trans_fwd),
   .degenerate (rsp_ch.degenerate)
);

`default_nettype wire
